[rtl/hcd_pkg.sv]
// Shared types, constants and helpers of the chunked body decoder
`timescale 1ns / 1ps
`default_nettype none

package hcd_pkg;

  // chunk size limit register
  localparam int unsigned LIMIT_W     = 30;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(512 * 1024 * 1024);

  // default width of the size accumulator
  localparam int unsigned SIZE_WIDTH_DEF = 34;

  // stream characters
  localparam logic [7:0] CHAR_SEMI = 8'h3b;
  localparam logic [7:0] CHAR_CR   = 8'h0d;
  localparam logic [7:0] CHAR_LF   = 8'h0a;

  // item commands
  localparam logic CMD_FEED    = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    STAT_BUSY  = 2'd0,
    STAT_DONE  = 2'd1,
    STAT_ERROR = 2'd2
  } status_e;

  // decoder phases
  typedef enum logic [2:0] {
    PH_SIZE    = 3'd0,
    PH_EXT     = 3'd1,
    PH_DATA    = 3'd2,
    PH_CRLF    = 3'd3,
    PH_TRAILER = 3'd4,
    PH_DONE    = 3'd5,
    PH_ERROR   = 3'd6
  } phase_e;

  // one decoded result
  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_payload;
    status_e    status;
  } result_t;

  // hex digit decode: {valid, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    case (c) inside
      [8'h30:8'h39]: r = {1'b1, c[3:0]};
      [8'h41:8'h46],
      [8'h61:8'h66]: r = {1'b1, c[3:0] + 4'd9};
      default:       r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/hcd_core.sv]
// Decoder state and per-byte step logic of the chunked body decoder
`timescale 1ns / 1ps
`default_nettype none

module hcd_core #(
  parameter int unsigned SIZE_WIDTH = hcd_pkg::SIZE_WIDTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          step_i,
  input  wire logic                          cmd_i,
  input  wire logic [7:0]                    byte_i,
  input  wire logic [hcd_pkg::LIMIT_W-1:0]   limit_i,
  output hcd_pkg::result_t                   result_o
);
  import hcd_pkg::*;

  // compare width covers both the shifted size and the limit
  localparam int unsigned CW = (SIZE_WIDTH + 4 > LIMIT_W) ? SIZE_WIDTH + 4 : LIMIT_W;

  phase_e                phase_q, phase_d;
  logic [SIZE_WIDTH-1:0] size_q, size_d;
  logic                  empty_q, empty_d;

  logic [4:0]            hex;
  logic [CW-1:0]         size_next;
  logic                  size_over;
  logic [SIZE_WIDTH-1:0] size_dec;

  // size accumulation and limit check
  always_comb begin
    hex       = hex_digit(byte_i);
    size_next = (CW'(size_q) << 4) | CW'(hex[3:0]);
    size_over = (size_next > CW'(limit_i)) || (size_q[SIZE_WIDTH-1 -: 4] != 4'd0);
    size_dec  = (size_q != '0) ? size_q - SIZE_WIDTH'(1) : size_q;
  end

  // next state
  always_comb begin
    phase_d = phase_q;
    size_d  = size_q;
    empty_d = empty_q;
    if (cmd_i == CMD_RESTART) begin
      phase_d = PH_SIZE;
      size_d  = '0;
      empty_d = 1'b1;
    end else begin
      unique case (phase_q)
        PH_SIZE: begin
          if (hex[4]) begin
            if (size_over) phase_d = PH_ERROR;
            else           size_d  = size_next[SIZE_WIDTH-1:0];
          end else if (byte_i == CHAR_SEMI) begin
            phase_d = PH_EXT;
          end else if (byte_i == CHAR_LF) begin
            phase_d = (size_q == '0) ? PH_TRAILER : PH_DATA;
            empty_d = 1'b1;
          end else if (byte_i != CHAR_CR) begin
            phase_d = PH_ERROR;
          end
        end
        PH_EXT: begin
          if (byte_i == CHAR_LF) begin
            phase_d = (size_q == '0) ? PH_TRAILER : PH_DATA;
            empty_d = 1'b1;
          end
        end
        PH_DATA: begin
          size_d = size_dec;
          if (size_dec == '0) phase_d = PH_CRLF;
        end
        PH_CRLF: begin
          if (byte_i == CHAR_LF) begin
            phase_d = PH_SIZE;
            size_d  = '0;
          end else if (byte_i != CHAR_CR) begin
            phase_d = PH_ERROR;
          end
        end
        PH_TRAILER: begin
          if (byte_i == CHAR_LF) begin
            if (empty_q) phase_d = PH_DONE;
            else         empty_d = 1'b1;
          end else if (byte_i != CHAR_CR) begin
            empty_d = 1'b0;
          end
        end
        PH_DONE:  phase_d = PH_DONE;
        PH_ERROR: phase_d = PH_ERROR;
        default:  phase_d = PH_ERROR;
      endcase
    end
  end

  // result of this byte
  always_comb begin
    result_o = '0;
    if (cmd_i == CMD_FEED && phase_q == PH_DATA) begin
      result_o.is_payload = 1'b1;
      result_o.out_byte   = byte_i;
    end
    unique case (phase_d)
      PH_DONE:  result_o.status = STAT_DONE;
      PH_SIZE, PH_EXT, PH_DATA, PH_CRLF, PH_TRAILER: result_o.status = STAT_BUSY;
      default:  result_o.status = STAT_ERROR;
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SIZE;
      size_q  <= '0;
      empty_q <= 1'b1;
    end else if (step_i) begin
      phase_q <= phase_d;
      size_q  <= size_d;
      empty_q <= empty_d;
    end
  end

endmodule

`default_nettype wire

[rtl/http_chunked_decoder_unit.sv]
// Top level of the HTTP/1.1 chunked body decoder with stream ports
// Path: an input transfer passes the input register and then the result register before its result transfer.
// Throughput: one byte per cycle while the result stream is not stalled; the size line,
// payload count and trailer state update in a single step between input and result register.
// Reset: asynchronous active low; clears pipeline valids, decoder phase and size,
// and loads the chunk size limit with 512 MiB. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module http_chunked_decoder_unit #(
  parameter int unsigned SIZE_WIDTH = hcd_pkg::SIZE_WIDTH_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // limit register write channel
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [hcd_pkg::LIMIT_W-1:0]  cfg_data_i,    // max_chunk_size
  // input stream
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [7:0]                   s_axis_tdata,  // [7:0] data_byte
  input  wire logic                         s_axis_tuser,  // [0] command
  // result stream
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  output logic [15:0]                       m_axis_tdata,  // [7:0] out_byte, [9:8] status
  output logic                              m_axis_tuser   // [0] is_payload
);
  import hcd_pkg::*;

  logic [LIMIT_W-1:0] limit_q;
  logic               in_valid_q;
  logic [7:0]         in_byte_q;
  logic               in_cmd_q;
  logic               out_valid_q;
  result_t            out_q;
  result_t            result;
  logic               advance;

  // limit register, always writable
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_valid_i) begin
      limit_q <= cfg_data_i;
    end
  end

  // a held byte steps the decoder when the result slot is free or draining
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_cmd_q  <= s_axis_tuser;
    end
  end

  // decoder step
  hcd_core #(
    .SIZE_WIDTH (SIZE_WIDTH)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .cmd_i    (in_cmd_q),
    .byte_i   (in_byte_q),
    .limit_i  (limit_q),
    .result_o (result)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result;
    end
  end

  // result port packing
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_q.status, out_q.out_byte};
  assign m_axis_tuser  = out_q.is_payload;

endmodule

`default_nettype wire

[tb/sv/http_chunked_decoder_unit_tb.sv]
// Self-checking testbench of the chunked body decoder with a stream driver and result monitor
`timescale 1ns / 1ps

module http_chunked_decoder_unit_tb;
  import hcd_pkg::*;

  localparam int unsigned SW = SIZE_WIDTH_DEF;
  localparam int unsigned PHASE_ITEMS = 230;

  typedef struct {
    logic       cmd;
    logic [7:0] data;
  } feed_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [LIMIT_W-1:0] cfg_data_i = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [7:0]        s_axis_tdata = 8'h00;
  logic              s_axis_tuser = CMD_FEED;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [15:0]       m_axis_tdata;
  logic              m_axis_tuser;

  http_chunked_decoder_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // pending stream bytes, expected decoder results, scratch message
  feed_t       feed_q[$];
  result_t     decoded_q[$];
  logic [7:0]  msg_q[$];
  int unsigned queued_total = 0;
  int unsigned fed_total = 0;
  int unsigned mismatch_count = 0;
  int unsigned feed_gap = 0;
  int unsigned sink_hold = 0;
  bit          calm = 1'b0;

  // decoder model state
  phase_e             dec_phase = PH_SIZE;
  logic [SW-1:0]      dec_size = '0;
  logic               dec_line_empty = 1'b1;
  logic [LIMIT_W-1:0] dec_limit = LIMIT_RESET;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #(10_000_000);
    $display("Simulation FAILED");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
    if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
    if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
    return -1;
  endfunction

  // one decoder step: advance the model and return the result it yields
  function automatic result_t decode_step(input logic cmd, input logic [7:0] c);
    result_t    r;
    int         d;
    logic [63:0] grown;
    r.out_byte   = 8'h00;
    r.is_payload = 1'b0;
    if (cmd == CMD_RESTART) begin
      dec_phase      = PH_SIZE;
      dec_size       = '0;
      dec_line_empty = 1'b1;
    end else begin
      case (dec_phase)
        PH_SIZE: begin
          d = hex_nibble(c);
          if (d >= 0) begin
            grown = 64'(dec_size) * 64'd16 + 64'(d);
            if (grown > 64'(dec_limit) || grown > ((64'd1 << SW) - 64'd1)) begin
              dec_phase = PH_ERROR;
            end else begin
              dec_size = grown[SW-1:0];
            end
          end else if (c == CHAR_SEMI) begin
            dec_phase = PH_EXT;
          end else if (c == CHAR_LF) begin
            dec_phase      = (dec_size == '0) ? PH_TRAILER : PH_DATA;
            dec_line_empty = 1'b1;
          end else if (c != CHAR_CR) begin
            dec_phase = PH_ERROR;
          end
        end
        PH_EXT: begin
          if (c == CHAR_LF) begin
            dec_phase      = (dec_size == '0) ? PH_TRAILER : PH_DATA;
            dec_line_empty = 1'b1;
          end
        end
        PH_DATA: begin
          r.is_payload = 1'b1;
          r.out_byte   = c;
          if (dec_size != '0) dec_size = dec_size - 1'b1;
          if (dec_size == '0) dec_phase = PH_CRLF;
        end
        PH_CRLF: begin
          if (c == CHAR_LF) begin
            dec_phase = PH_SIZE;
            dec_size  = '0;
          end else if (c != CHAR_CR) begin
            dec_phase = PH_ERROR;
          end
        end
        PH_TRAILER: begin
          if (c == CHAR_LF) begin
            if (dec_line_empty) dec_phase = PH_DONE;
            else dec_line_empty = 1'b1;
          end else if (c != CHAR_CR) begin
            dec_line_empty = 1'b0;
          end
        end
        PH_DONE: ;
        default: dec_phase = PH_ERROR;
      endcase
    end
    if (dec_phase == PH_DONE) r.status = STAT_DONE;
    else if (dec_phase == PH_SIZE || dec_phase == PH_EXT || dec_phase == PH_DATA ||
             dec_phase == PH_CRLF || dec_phase == PH_TRAILER) r.status = STAT_BUSY;
    else r.status = STAT_ERROR;
    return r;
  endfunction

  // input driver: the model advances on every accepted transfer
  always @(posedge clk_i) begin : drive
    feed_t it;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        decoded_q.push_back(decode_step(s_axis_tuser, s_axis_tdata));
        fed_total++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (feed_gap > 0) begin
          feed_gap <= feed_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (feed_q.size() > 0) begin
          it = feed_q.pop_front();
          s_axis_tdata  <= it.data;
          s_axis_tuser  <= it.cmd;
          s_axis_tvalid <= 1'b1;
          feed_gap      <= pick_gap();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random back-pressure
  always @(posedge clk_i) begin : watch
    result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (decoded_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result tdata=%h tuser=%b",
                                    m_axis_tdata, m_axis_tuser));
        end else begin
          want = decoded_q.pop_front();
          if (m_axis_tdata[7:0] !== want.out_byte)
            report_mismatch($sformatf("out_byte %h, expected %h",
                                      m_axis_tdata[7:0], want.out_byte));
          if (m_axis_tuser !== want.is_payload)
            report_mismatch($sformatf("is_payload %b, expected %b",
                                      m_axis_tuser, want.is_payload));
          if (m_axis_tdata[9:8] !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      m_axis_tdata[9:8], want.status));
        end
      end
      if (sink_hold > 0) begin
        sink_hold <= sink_hold - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        sink_hold     <= pick_gap();
      end
    end
  end

  task automatic feed(input logic [7:0] c);
    feed_q.push_back('{cmd: CMD_FEED, data: c});
    queued_total++;
  endtask

  task automatic restart(input logic [7:0] c);
    feed_q.push_back('{cmd: CMD_RESTART, data: c});
    queued_total++;
  endtask

  // hex digits of a size, random letter case and optional leading zeros
  task automatic put_hex(input logic [63:0] v);
    int unsigned n;
    logic [3:0]  nib;
    bit          upper;
    n = 1;
    upper = 1'($urandom_range(0, 1));
    while (n < 16 && (v >> (4 * n)) != 0) n++;
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) msg_q.push_back(8'h30);
    for (int i = n - 1; i >= 0; i--) begin
      nib = v[4*i +: 4];
      if (nib < 10) msg_q.push_back(8'h30 + nib);
      else msg_q.push_back((upper ? 8'h41 : 8'h61) + nib - 8'd10);
    end
  endtask

  function automatic logic [7:0] any_but_lf();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    return (c == CHAR_LF) ? 8'h54 : c;
  endfunction

  task automatic put_size_line(input logic [63:0] v);
    if ($urandom_range(0, 9) == 0) msg_q.push_back(CHAR_CR);
    put_hex(v);
    if ($urandom_range(0, 4) == 0) begin
      msg_q.push_back(CHAR_SEMI);
      repeat ($urandom_range(0, 5)) msg_q.push_back(any_but_lf());
    end
    if ($urandom_range(0, 19) != 0) msg_q.push_back(CHAR_CR);
    msg_q.push_back(CHAR_LF);
  endtask

  // one message: mostly well formed, some oversized, corrupted, cut or noise
  task automatic queue_message(input logic [LIMIT_W-1:0] lim);
    int unsigned r, sz, pos;
    msg_q.delete();
    r = $urandom_range(0, 99);
    if (r < 5) begin
      repeat ($urandom_range(1, 12)) msg_q.push_back(8'($urandom_range(0, 255)));
    end else if (r < 13) begin
      if ($urandom_range(0, 3) == 0) put_hex((64'd1 << SW) - 64'd1);
      else put_hex(64'(lim) + 64'd1 + 64'($urandom_range(0, 15)));
      repeat ($urandom_range(0, 3)) msg_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 3)) begin
        pos = $urandom_range(0, 99);
        if (pos < 80) sz = $urandom_range(1, 12);
        else if (pos < 96) sz = $urandom_range(13, 64);
        else sz = $urandom_range(200, 300);
        if (sz > lim) sz = 32'(lim);
        if (sz != 0) begin
          put_size_line(64'(sz));
          repeat (sz) msg_q.push_back(8'($urandom_range(0, 255)));
          if ($urandom_range(0, 9) != 0) msg_q.push_back(CHAR_CR);
          if ($urandom_range(0, 14) == 0) msg_q.push_back(CHAR_CR);
          msg_q.push_back(CHAR_LF);
        end
      end
      // last chunk, possibly as an empty size line
      if ($urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 1) == 1) msg_q.push_back(CHAR_CR);
        msg_q.push_back(CHAR_LF);
      end else begin
        put_size_line(64'd0);
      end
      repeat ($urandom_range(0, 2)) begin
        repeat ($urandom_range(1, 6)) msg_q.push_back(any_but_lf());
        if ($urandom_range(0, 4) != 0) msg_q.push_back(CHAR_CR);
        msg_q.push_back(CHAR_LF);
      end
      if ($urandom_range(0, 4) != 0) msg_q.push_back(CHAR_CR);
      msg_q.push_back(CHAR_LF);
      if ($urandom_range(0, 6) == 0)
        repeat ($urandom_range(1, 4)) msg_q.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 6) == 0) begin
        pos = $urandom_range(0, msg_q.size() - 1);
        msg_q[pos] = 8'($urandom_range(0, 255));
      end
      if ($urandom_range(0, 11) == 0) begin
        pos = $urandom_range(0, msg_q.size() - 1);
        while (msg_q.size() > pos) void'(msg_q.pop_back());
      end
    end
    foreach (msg_q[i]) feed(msg_q[i]);
    restart(8'($urandom_range(0, 255)));
  endtask

  // wait until every queued byte was taken and every result came back
  task automatic drain();
    while (fed_total != queued_total || decoded_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] v);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!(cfg_valid_i && cfg_ready_o)) @(posedge clk_i);
    dec_limit = v;
    cfg_valid_i <= 1'b0;
  endtask

  // stimulus: directed bytes, then random messages under several limits
  initial begin
    logic [LIMIT_W-1:0] limits[7];
    int unsigned        stop_at;
    limits = '{LIMIT_RESET, '0, {LIMIT_W{1'b1}}, LIMIT_W'(5), LIMIT_W'($urandom_range(16, 400)),
               LIMIT_W'($urandom), LIMIT_RESET};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: CR on size line, extremes of payload, extension, trailers,
    // bytes after completion, empty size line, bad bytes, restart
    restart(8'hff);
    feed(CHAR_CR); feed(8'h31); feed(CHAR_LF);
    feed(8'h00); feed(CHAR_CR); feed(CHAR_LF);
    feed(8'h30); feed(CHAR_SEMI); feed(8'hff); feed(CHAR_LF);
    feed(8'h58); feed(CHAR_CR); feed(CHAR_LF);
    feed(CHAR_CR); feed(CHAR_LF);
    feed(8'h41);
    restart(8'h00);
    feed(CHAR_LF); feed(CHAR_LF);
    restart(8'h00);
    feed(8'h47); feed(8'h35);
    restart(8'hff);
    feed(8'h31); feed(CHAR_LF); feed(8'hff); feed(8'h5a);
    restart(8'h00);

    foreach (limits[k]) begin
      if (k != 0) begin
        drain();
        write_limit(limits[k]);
      end
      stop_at = queued_total + PHASE_ITEMS;
      while (queued_total < stop_at) begin
        calm = ($urandom_range(0, 7) == 0);
        queue_message(limits[k]);
      end
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/hcd_pkg.sv
rtl/hcd_core.sv
rtl/http_chunked_decoder_unit.sv
tb/sv/http_chunked_decoder_unit_tb.sv
